### hw/rtl/pfx_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the postfix expression evaluator.
// No dependencies; used by pfx_alu and the top level of the block.
package pfx_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;

    // ASCII codes the evaluator reacts to
    localparam logic [7:0] SYM_ZERO  = 8'h30;
    localparam logic [7:0] SYM_NINE  = 8'h39;
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_MINUS = 8'h2D;
    localparam logic [7:0] SYM_TIMES = 8'h2A;
    localparam logic [7:0] SYM_DIV   = 8'h2F;

    // value of a pop from an empty stack
    localparam logic [DATA_W-1:0] VAL_EMPTY = '1;

    typedef logic [1:0] t_alu_op;
    localparam t_alu_op OP_ADD = 2'd0;
    localparam t_alu_op OP_SUB = 2'd1;
    localparam t_alu_op OP_MUL = 2'd2;
    localparam t_alu_op OP_DIV = 2'd3;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic div_zero;
    } t_alu_rsp;

endpackage

### hw/rtl/pfx_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the last read word until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pfx_alu.sv
`timescale 1ns / 1ps
// Shared arithmetic unit: add, subtract and multiply with a registered result, signed
// division by restoring steps, one quotient bit per cycle. Uses pfx_pkg.
module pfx_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfx_pkg::t_alu_req             i_req,
    input  logic [pfx_pkg::DATA_W-1:0]    i_lhs,
    input  logic [pfx_pkg::DATA_W-1:0]    i_rhs,
    output pfx_pkg::t_alu_rsp             o_rsp,
    output logic [pfx_pkg::DATA_W-1:0]    o_result
);

    localparam int W  = pfx_pkg::DATA_W;
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_div;
    logic          r_neg;
    logic          r_done;
    logic          r_dz;
    logic [W-1:0]  r_result;

    logic [W-1:0]  mag_l;
    logic [W-1:0]  mag_r;
    logic [W-1:0]  shifted;
    logic [W:0]    diff;
    logic [W-1:0]  quo_next;

    assign mag_l    = i_lhs[W-1] ? (~i_lhs + 1'b1) : i_lhs;
    assign mag_r    = i_rhs[W-1] ? (~i_rhs + 1'b1) : i_rhs;
    assign shifted  = {r_rem[W-2:0], r_quo[W-1]};
    assign diff     = {1'b0, shifted} - {1'b0, r_div};
    assign quo_next = {r_quo[W-2:0], ~diff[W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_dz   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_dz   <= 1'b0;
            if (r_busy) begin
                // one restoring step
                r_rem <= diff[W] ? shifted : diff[W-1:0];
                r_quo <= quo_next;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy   <= 1'b0;
                    r_done   <= 1'b1;
                    r_result <= r_neg ? (~quo_next + 1'b1) : quo_next;
                end
            end else if (i_req.start) begin
                unique case (i_req.op)
                    pfx_pkg::OP_ADD: begin
                        r_result <= i_lhs + i_rhs;
                        r_done   <= 1'b1;
                    end
                    pfx_pkg::OP_SUB: begin
                        r_result <= i_lhs - i_rhs;
                        r_done   <= 1'b1;
                    end
                    pfx_pkg::OP_MUL: begin
                        r_result <= i_lhs * i_rhs;
                        r_done   <= 1'b1;
                    end
                    default: begin
                        if (i_rhs == '0) begin
                            r_result <= '0;
                            r_dz     <= 1'b1;
                            r_done   <= 1'b1;
                        end else begin
                            r_busy <= 1'b1;
                            r_cnt  <= CW'(W - 1);
                            r_rem  <= '0;
                            r_quo  <= mag_l;
                            r_div  <= mag_r;
                            r_neg  <= i_lhs[W-1] ^ i_rhs[W-1];
                        end
                    end
                endcase
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.div_zero = r_dz;
    assign o_result       = r_result;

endmodule

### hw/rtl/postfix_expression_evaluator.sv
`timescale 1ns / 1ps
// Top level of the postfix expression evaluator: sequencer, stack pointer,
// sticky flags and result register. Uses pfx_pkg, pfx_ram and pfx_alu.
//
// The evaluator takes one ASCII character per input transfer. A digit pushes
// its value, + - * / pop the right then the left operand and push the 32-bit
// wrapped result (division truncates toward zero, a zero divisor gives 0 and
// sets div_zero_seen). A pop from an empty stack gives -1 and sets
// underflow_seen; a push onto a full stack is dropped and sets overflow_seen.
// On the character marked end_of_expr the top is popped and sent out with
// the three flags, and stack and flags clear for the next expression. The
// block handles one character at a time and is not ready meanwhile; a
// division with a nonzero divisor waits on the one-bit-per-cycle divide in
// the shared arithmetic unit. The final character adds the closing pop plus
// any wait for the result register to drain. The stack lives in a RAM with
// registered read, so each pop reads the word before it is used; it needs
// no clearing since the stack pointer says which entries hold data.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_symbol,
    input  logic                       i_end_of_expr,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [pfx_pkg::DATA_W-1:0] o_value,
    output logic                       o_overflow_seen,
    output logic                       o_underflow_seen,
    output logic                       o_div_zero_seen
);

    localparam int W  = pfx_pkg::DATA_W;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_POP_R = 4'd1;
    localparam logic [3:0] S_POP_L = 4'd2;
    localparam logic [3:0] S_LHS   = 4'd3;
    localparam logic [3:0] S_EXEC  = 4'd4;
    localparam logic [3:0] S_WAIT  = 4'd5;
    localparam logic [3:0] S_PUSH  = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0]        r_state;
    logic              r_last;
    pfx_pkg::t_alu_op  r_op;
    logic [W-1:0]      r_lhs;
    logic [W-1:0]      r_rhs;
    logic [W-1:0]      r_res;
    logic              r_take;     // RAM read data holds the popped word
    logic [CW-1:0]     r_count;
    logic              r_of;
    logic              r_uf;
    logic              r_dz;
    logic              r_out_valid;
    logic [W-1:0]      r_value;
    logic              r_out_of;
    logic              r_out_uf;
    logic              r_out_dz;

    logic              accept;
    logic              is_digit;
    logic              is_op;
    pfx_pkg::t_alu_op  sym_op;
    logic              empty;
    logic              full;
    logic [CW-1:0]     count_dec;
    logic              ram_we;
    logic              ram_re;
    logic [W-1:0]      ram_rdata;
    logic              out_free;
    pfx_pkg::t_alu_req alu_req;
    pfx_pkg::t_alu_rsp alu_rsp;
    logic [W-1:0]      alu_result;

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign empty     = (r_count == '0);
    assign full      = (r_count >= CW'(STACK_DEPTH));
    assign count_dec = r_count - 1'b1;
    assign out_free  = !r_out_valid || i_ready;
    assign is_digit  = (i_symbol >= pfx_pkg::SYM_ZERO) && (i_symbol <= pfx_pkg::SYM_NINE);

    always_comb begin
        is_op  = 1'b1;
        sym_op = pfx_pkg::OP_ADD;
        unique case (i_symbol)
            pfx_pkg::SYM_PLUS:  sym_op = pfx_pkg::OP_ADD;
            pfx_pkg::SYM_MINUS: sym_op = pfx_pkg::OP_SUB;
            pfx_pkg::SYM_TIMES: sym_op = pfx_pkg::OP_MUL;
            pfx_pkg::SYM_DIV:   sym_op = pfx_pkg::OP_DIV;
            default:            is_op  = 1'b0;
        endcase
    end

    // Pop reads go out at the current top; for operand pops the pointer drops in the same cycle.
    assign ram_re = !empty &&
                    ((r_state == S_POP_R) || (r_state == S_POP_L) ||
                     ((r_state == S_FIN) && r_last));
    assign ram_we = (r_state == S_PUSH) && !full;

    assign alu_req.start = (r_state == S_EXEC);
    assign alu_req.op    = r_op;

    pfx_ram #(
        .WIDTH(W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(r_res),
        .i_re   (ram_re),
        .i_raddr(count_dec[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    pfx_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_lhs   (r_lhs),
        .i_rhs   (r_rhs),
        .o_rsp   (alu_rsp),
        .o_result(alu_result)
    );

    // load a finished result; drop it once the consumer takes the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_of        <= 1'b0;
            r_uf        <= 1'b0;
            r_dz        <= 1'b0;
            r_take      <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last <= i_end_of_expr;
                        r_op   <= sym_op;
                        r_res  <= W'(i_symbol - pfx_pkg::SYM_ZERO);
                        if (is_digit) begin
                            r_state <= S_PUSH;
                        end else if (is_op) begin
                            r_state <= S_POP_R;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_POP_R: begin
                    // right operand
                    r_rhs <= pfx_pkg::VAL_EMPTY;
                    if (empty) begin
                        r_uf   <= 1'b1;
                        r_take <= 1'b0;
                    end else begin
                        r_count <= count_dec;
                        r_take  <= 1'b1;
                    end
                    r_state <= S_POP_L;
                end
                S_POP_L: begin
                    // capture right word, then pop left operand
                    if (r_take) begin
                        r_rhs <= ram_rdata;
                    end
                    r_lhs <= pfx_pkg::VAL_EMPTY;
                    if (empty) begin
                        r_uf   <= 1'b1;
                        r_take <= 1'b0;
                    end else begin
                        r_count <= count_dec;
                        r_take  <= 1'b1;
                    end
                    r_state <= S_LHS;
                end
                S_LHS: begin
                    if (r_take) begin
                        r_lhs <= ram_rdata;
                    end
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (alu_rsp.done) begin
                        r_res <= alu_result;
                        if (alu_rsp.div_zero) begin
                            r_dz <= 1'b1;
                        end
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (full) begin
                        r_of <= 1'b1;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        // closing pop; its underflow counts toward the result
                        if (empty) begin
                            r_uf   <= 1'b1;
                            r_take <= 1'b0;
                        end else begin
                            r_take <= 1'b1;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // hold until the result register is free
                    if (out_free) begin
                        r_value     <= r_take ? ram_rdata : pfx_pkg::VAL_EMPTY;
                        r_out_of    <= r_of;
                        r_out_uf    <= r_uf;
                        r_out_dz    <= r_dz;
                        r_count     <= '0;
                        r_of        <= 1'b0;
                        r_uf        <= 1'b0;
                        r_dz        <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_value          = r_value;
    assign o_overflow_seen  = r_out_of;
    assign o_underflow_seen = r_out_uf;
    assign o_div_zero_seen  = r_out_dz;

endmodule
